// ===== hdl/cmf_pkg.sv =====
// Package for the cross morphology filter.
// Shared types and constants; no dependencies.
package cmf_pkg;

	localparam int PIXEL_W    = 8;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int CFG_DATA_W = 13;
	localparam int REG_IDX_W  = 2;

	localparam logic [PIXEL_W-1:0]  KEY_DARK     = 8'd0;
	localparam logic [PIXEL_W-1:0]  KEY_BRIGHT   = 8'd255;
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MODE   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} cfg_reg_t;

	// position of the pixel being transferred in
	typedef struct packed {
		logic first_col;
		logic last_col;
		logic last_row;
		logic has_above;
		logic has_two_above;
	} pos_flags_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               frame_end;
	} result_t;

endpackage

// ===== hdl/cmf_line_store.sv =====
// Line store: one write port, N_RD registered read ports.
// Depends on nothing; widths come from parameters.
module cmf_line_store #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 8,
	parameter int N_RD   = 1,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr [N_RD],
	output logic [DATA_W-1:0] rd_data [N_RD]
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read-before-write on a shared address
	always_ff @(posedge clk) begin
		if (rd_en) begin
			for (int i = 0; i < N_RD; i++) begin
				rd_data[i] <= mem[rd_addr[i]];
			end
		end
	end

endmodule

// ===== hdl/cmf_raster_ctrl.sv =====
// Raster position counters with frame size clamping.
// Depends on cmf_pkg.
module cmf_raster_ctrl #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096,
	parameter int CW = $clog2(MAX_WIDTH),
	parameter int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [cmf_pkg::WIDTH_W-1:0]  frame_width,
	input  logic [cmf_pkg::HEIGHT_W-1:0] frame_height,
	input  logic                         advance,
	output logic [CW-1:0]                col,
	output cmf_pkg::pos_flags_t          flags
);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_last;
	logic [RW-1:0] row_last;
	logic [RW-1:0] row;

	always_comb begin
		if (frame_width == '0) begin
			col_last = '0;
		end else if (32'(frame_width) > MAX_WIDTH) begin
			col_last = CW'(MAX_WIDTH - 1);
		end else begin
			col_last = CW'(32'(frame_width) - 1);
		end
		if (frame_height == '0) begin
			row_last = '0;
		end else if (32'(frame_height) > MAX_HEIGHT) begin
			row_last = RW'(MAX_HEIGHT - 1);
		end else begin
			row_last = RW'(32'(frame_height) - 1);
		end
		col = (col_q >= col_last) ? col_last : col_q;
		row = (row_q >= row_last) ? row_last : row_q;
		flags.first_col     = (col == '0);
		flags.last_col      = (col == col_last);
		flags.last_row      = (row == row_last);
		flags.has_above     = (row != '0);
		flags.has_two_above = (32'(row) >= 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (flags.last_col) begin
				col_q <= '0;
				row_q <= flags.last_row ? '0 : row + 1'b1;
			end else begin
				col_q <= col + 1'b1;
				row_q <= row;
			end
		end
	end

endmodule

// ===== hdl/cmf_out_buf.sv =====
// Two-slot result register feeding the output channel.
// Depends on cmf_pkg.
module cmf_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              slot0_valid,
	input  cmf_pkg::result_t  slot0,
	input  logic              slot1_valid,
	input  cmf_pkg::result_t  slot1,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        pixel_out,
	output logic              frame_end
);

	logic             v0_s2;
	logic             v1_s2;
	cmf_pkg::result_t d0_s2;
	cmf_pkg::result_t d1_s2;
	logic             pop;

	assign out_valid = v0_s2 | v1_s2;
	assign pop       = out_valid & out_ready;
	assign free      = (!v0_s2 && !v1_s2) || ((v0_s2 ^ v1_s2) && out_ready);
	assign pixel_out = v0_s2 ? d0_s2.pixel : d1_s2.pixel;
	assign frame_end = v0_s2 ? d0_s2.frame_end : d1_s2.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_s2 <= 1'b0;
			v1_s2 <= 1'b0;
		end else if (load) begin
			v0_s2 <= slot0_valid;
			v1_s2 <= slot1_valid;
		end else if (pop) begin
			if (v0_s2) begin
				v0_s2 <= 1'b0;
			end else begin
				v1_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			d0_s2 <= slot0;
			d1_s2 <= slot1;
		end
	end

endmodule

// ===== hdl/cross_morphology_filter.sv =====
// Cross morphology filter, top level: config registers, line stores, s1 stage.
// Depends on cmf_pkg, cmf_line_store, cmf_raster_ctrl, cmf_out_buf.
// Each accepted pixel is registered in s1, then loaded into the output register when that is
// free, and transfers out from there; the filtered pixel is one row behind the input.
// Throughput: one pixel per clock unless the output stalls; on the last row of a frame taller
// than one row each pixel yields two results through the single output port, stalling input.
// Reset clears counters, stage valids and config; line stores are not cleared.
module cross_morphology_filter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           write_enable,
	input  logic [cmf_pkg::REG_IDX_W-1:0]  reg_index,
	input  logic [cmf_pkg::CFG_DATA_W-1:0] write_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     pixel_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     pixel_out,
	output logic                           frame_end
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic                         mode_q;
	logic [cmf_pkg::WIDTH_W-1:0]  width_q;
	logic [cmf_pkg::HEIGHT_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			width_q  <= cmf_pkg::WIDTH_RESET;
			height_q <= cmf_pkg::HEIGHT_RESET;
		end else if (write_enable) begin
			case (cmf_pkg::cfg_reg_t'(reg_index))
				cmf_pkg::REG_MODE:   mode_q   <= write_data[0];
				cmf_pkg::REG_WIDTH:  width_q  <= write_data[cmf_pkg::WIDTH_W-1:0];
				cmf_pkg::REG_HEIGHT: height_q <= write_data;
				default: ;
			endcase
		end
	end

	logic                in_xfer;
	logic [CW-1:0]       col;
	cmf_pkg::pos_flags_t flags;

	cmf_raster_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_raster (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (width_q),
		.frame_height (height_q),
		.advance      (in_xfer),
		.col          (col),
		.flags        (flags)
	);

	// s1 stage
	logic                valid_s1;
	logic [7:0]          px_s1;
	logic [CW-1:0]       col_s1;
	cmf_pkg::pos_flags_t flags_s1;
	logic [7:0]          left_s1;
	logic                wr2_q;
	logic                s2_free;
	logic                s1_adv;

	logic [CW-1:0] above_addr [2];
	logic [7:0]    above_data [2];
	logic [CW-1:0] two_addr   [1];
	logic [7:0]    two_data   [1];

	assign above_addr[0] = col;
	assign above_addr[1] = col + 1'b1;
	assign two_addr[0]   = col;

	// above_data[0] is the centre, above_data[1] the right neighbour
	cmf_line_store #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (8),
		.N_RD   (2)
	) u_line_above (
		.clk     (clk),
		.wr_en   (in_xfer),
		.wr_addr (col),
		.wr_data (pixel_in),
		.rd_en   (in_xfer),
		.rd_addr (above_addr),
		.rd_data (above_data)
	);

	// centre moves down one row the cycle after transfer
	cmf_line_store #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (8),
		.N_RD   (1)
	) u_line_two_above (
		.clk     (clk),
		.wr_en   (wr2_q),
		.wr_addr (col_s1),
		.wr_data (above_data[0]),
		.rd_en   (in_xfer),
		.rd_addr (two_addr),
		.rd_data (two_data)
	);

	assign s1_adv   = valid_s1 & s2_free;
	assign in_ready = !valid_s1 || s2_free;
	assign in_xfer  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wr2_q    <= 1'b0;
		end else begin
			wr2_q <= in_xfer;
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			px_s1    <= pixel_in;
			col_s1   <= col;
			flags_s1 <= flags;
			left_s1  <= above_data[0];
		end
	end

	logic [7:0]       key;
	logic             interior;
	logic             hit;
	cmf_pkg::result_t res0;
	cmf_pkg::result_t res1;

	always_comb begin
		key      = mode_q ? cmf_pkg::KEY_BRIGHT : cmf_pkg::KEY_DARK;
		interior = flags_s1.has_two_above && !flags_s1.first_col && !flags_s1.last_col;
		hit      = (above_data[0] == key) || (two_data[0] == key) || (left_s1 == key)
			|| (above_data[1] == key) || (px_s1 == key);
		res0.pixel     = (interior && hit) ? key : above_data[0];
		res0.frame_end = 1'b0;
		res1.pixel     = px_s1;
		res1.frame_end = flags_s1.last_col;
	end

	cmf_out_buf u_out_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (s1_adv),
		.slot0_valid (flags_s1.has_above),
		.slot0       (res0),
		.slot1_valid (flags_s1.last_row),
		.slot1       (res1),
		.free        (s2_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_out   (pixel_out),
		.frame_end   (frame_end)
	);

endmodule

// ===== tb/cmf_checker.sv =====
// Scoreboard for the cross morphology filter: watches config writes and both pixel channels.
// Keeps its own copy of the line stores and raster counters and checks every output transfer.
// Depends on cmf_pkg.
`timescale 1ns / 100ps

module cmf_checker #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           write_enable,
	input  logic [cmf_pkg::REG_IDX_W-1:0]  reg_index,
	input  logic [cmf_pkg::CFG_DATA_W-1:0] write_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [7:0]                     pixel_in,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [7:0]                     pixel_out,
	input  logic                           frame_end,
	output int                             mismatch_count,
	output int                             results_due
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	logic                         mode_q;
	logic [cmf_pkg::WIDTH_W-1:0]  width_q;
	logic [cmf_pkg::HEIGHT_W-1:0] height_q;

	logic [cmf_pkg::PIXEL_W-1:0] row_above     [MAX_WIDTH];
	logic [cmf_pkg::PIXEL_W-1:0] row_two_above [MAX_WIDTH];
	logic [cmf_pkg::PIXEL_W-1:0] left_above;
	logic [COL_W-1:0]            col_cnt;
	logic [ROW_W-1:0]            row_cnt;

	cmf_pkg::result_t predicted_pixels [$];

	// one accepted pixel: update the line stores and queue the pixels it releases
	task automatic filter_pixel(input logic [cmf_pkg::PIXEL_W-1:0] px);
		logic [COL_W-1:0]            last_c, c;
		logic [ROW_W-1:0]            last_r, r;
		logic                        last_col, last_row;
		logic [cmf_pkg::PIXEL_W-1:0] centre, key;
		cmf_pkg::result_t            res;
		if (width_q == 0)
			last_c = '0;
		else if (width_q > MAX_WIDTH)
			last_c = COL_W'(MAX_WIDTH - 1);
		else
			last_c = COL_W'(width_q - 1'b1);
		if (height_q == 0)
			last_r = '0;
		else if (height_q > MAX_HEIGHT)
			last_r = ROW_W'(MAX_HEIGHT - 1);
		else
			last_r = ROW_W'(height_q - 1'b1);
		c        = (col_cnt >= last_c) ? last_c : col_cnt;
		r        = (row_cnt >= last_r) ? last_r : row_cnt;
		last_col = (c == last_c);
		last_row = (r == last_r);

		if (r != 0) begin
			centre    = row_above[c];
			res.pixel = centre;
			key       = mode_q ? cmf_pkg::KEY_BRIGHT : cmf_pkg::KEY_DARK;
			if (r != 1 && c != 0 && !last_col) begin
				if (centre == key || row_two_above[c] == key || left_above == key ||
				    row_above[c + 1] == key || px == key)
					res.pixel = key;
			end
			res.frame_end = 1'b0;
			predicted_pixels.push_back(res);
		end
		if (last_row) begin
			res.pixel     = px;
			res.frame_end = last_col;
			predicted_pixels.push_back(res);
		end

		left_above       = row_above[c];
		row_two_above[c] = row_above[c];
		row_above[c]     = px;
		if (last_col) begin
			col_cnt = '0;
			row_cnt = last_row ? '0 : r + 1'b1;
		end else begin
			col_cnt = c + 1'b1;
			row_cnt = r;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cmf_pkg::result_t want;
		if (!arst_n) begin
			mode_q     = 1'b0;
			width_q    = cmf_pkg::WIDTH_RESET;
			height_q   = cmf_pkg::HEIGHT_RESET;
			left_above = '0;
			col_cnt    = '0;
			row_cnt    = '0;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				row_above[i]     = '0;
				row_two_above[i] = '0;
			end
			predicted_pixels.delete();
			mismatch_count = 0;
			results_due    = 0;
		end else begin
			if (write_enable) begin
				case (cmf_pkg::cfg_reg_t'(reg_index))
					cmf_pkg::REG_MODE:   mode_q   = write_data[0];
					cmf_pkg::REG_WIDTH:  width_q  = write_data[cmf_pkg::WIDTH_W-1:0];
					cmf_pkg::REG_HEIGHT: height_q = write_data[cmf_pkg::HEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				filter_pixel(pixel_in);
			if (out_valid && out_ready) begin
				if (predicted_pixels.size() == 0) begin
					$display("%0t: unexpected transfer, expected none, %s=%0d frame_end=%0b",
						$time, "got pixel_out", pixel_out, frame_end);
					mismatch_count++;
				end else begin
					want = predicted_pixels.pop_front();
					if (pixel_out !== want.pixel) begin
						$display("%0t: pixel_out expected %0d, got %0d",
							$time, want.pixel, pixel_out);
						mismatch_count++;
					end
					if (frame_end !== want.frame_end) begin
						$display("%0t: frame_end expected %0b, got %0b",
							$time, want.frame_end, frame_end);
						mismatch_count++;
					end
				end
			end
			results_due = predicted_pixels.size();
		end
	end

endmodule

// ===== tb/tb_cross_morphology_filter.sv =====
// Testbench top for cross_morphology_filter: clock, reset, config writes and pixel stimulus.
// Checking is done by cmf_checker; this module gives the verdict from its mismatch count.
// Depends on cmf_pkg, cmf_checker and the filter RTL.
`timescale 1ns / 100ps

module tb_cross_morphology_filter;

	localparam int MAX_W        = 1024;
	localparam int MAX_H        = 4096;
	localparam int SETTLE       = 8;
	localparam int RANDOM_ITEMS = 400;

	logic                           clk;
	logic                           arst_n;
	logic                           write_enable;
	cmf_pkg::cfg_reg_t              reg_index;
	logic [cmf_pkg::CFG_DATA_W-1:0] write_data;
	logic                           in_valid;
	logic                           in_ready;
	logic [7:0]                     pixel_in;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [7:0]                     pixel_out;
	logic                           frame_end;
	int                             mismatch_count;
	int                             results_due;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int pixels_sent   = 0;

	// 3x3 frame whose centre sees a dark and a bright neighbour
	logic [7:0] probe [9] = '{8'd200, 8'd255, 8'd17, 8'd90, 8'd128, 8'd77, 8'd1, 8'd0, 8'd254};

	cross_morphology_filter #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.write_enable(write_enable),
		.reg_index   (reg_index),
		.write_data  (write_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_in    (pixel_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_out   (pixel_out),
		.frame_end   (frame_end)
	);

	cmf_checker #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.write_enable  (write_enable),
		.reg_index     (reg_index),
		.write_data    (write_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pixel_in      (pixel_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_out     (pixel_out),
		.frame_end     (frame_end),
		.mismatch_count(mismatch_count),
		.results_due   (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(7))
			0, 1:    return cmf_pkg::KEY_DARK;
			2, 3:    return cmf_pkg::KEY_BRIGHT;
			4:       return $urandom_range(1) ? 8'd1 : 8'd254;
			default: return 8'($urandom);
		endcase
	endfunction

	// called right after a rising edge; returns right after the accepting edge
	task automatic send_pixel(input logic [7:0] px);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= px;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		pixels_sent++;
	endtask

	// hold off input until every predicted pixel has been transferred out
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (results_due != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(input logic [12:0] mode_val, input logic [12:0] width_val,
	                         input logic [12:0] height_val);
		drain();
		write_enable <= 1'b1;
		reg_index    <= cmf_pkg::REG_MODE;
		write_data   <= mode_val;
		@(posedge clk);
		reg_index    <= cmf_pkg::REG_WIDTH;
		write_data   <= width_val;
		@(posedge clk);
		reg_index    <= cmf_pkg::REG_HEIGHT;
		write_data   <= height_val;
		@(posedge clk);
		write_enable <= 1'b0;
	endtask

	initial begin
		int w, h, k, c0, r0, w2, h2, r_end, rest, first_random, frame_no;
		arst_n       = 1'b0;
		write_enable = 1'b0;
		reg_index    = cmf_pkg::REG_MODE;
		write_data   = '0;
		in_valid     = 1'b0;
		pixel_in     = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// erode then dilate on the same 3x3 frame; only bit 0 of the mode write counts
		configure(13'h1FFE, 13'd3, 13'd3);
		foreach (probe[i]) send_pixel(probe[i]);
		configure(13'h1001, 13'd3, 13'd3);
		foreach (probe[i]) send_pixel(probe[i]);
		// zero sizes act as a single pixel frame
		configure(13'h0000, 13'h0000, 13'h0000);
		send_pixel(8'hA5);
		// height beyond the maximum, then cut short mid-frame: row 2 folds onto row 1
		configure(13'h0001, 13'd2, 13'h1FFF);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h80);
		send_pixel(8'h7F);
		configure(13'h0001, 13'd2, 13'd2);
		send_pixel(8'h5A);
		send_pixel(8'hFF);

		// width beyond the maximum: one full 1024-pixel row
		stall_pct = 47;
		configure(13'h0000, 13'h1FFF, 13'd1);
		repeat (MAX_W) send_pixel(rand_pixel());

		first_random = pixels_sent;
		frame_no     = 0;
		w            = 1;
		h            = 1;
		while (pixels_sent - first_random < RANDOM_ITEMS) begin
			case (frame_no % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 47; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 47; end
				default: begin send_idle_pct = 37; stall_pct = 37; end
			endcase
			if (frame_no == 0 || $urandom_range(1)) begin
				w = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
				h = $urandom_range(1, 8);
				configure(13'($urandom_range(8191)),
					(w == 1 && $urandom_range(1)) ? 13'd0 : 13'(w), 13'(h));
			end
			if (w * h > 1 && $urandom_range(7) == 0) begin
				// resize mid-frame: width may only shrink, height may go either way
				k  = $urandom_range(1, w * h - 1);
				repeat (k) send_pixel(rand_pixel());
				r0 = k / w;
				c0 = k % w;
				w2 = $urandom_range(1, w);
				h2 = $urandom_range(1, 8);
				configure(13'($urandom_range(8191)), 13'(w2), 13'(h2));
				r_end = (r0 >= h2 - 1) ? h2 - 1 : r0;
				rest  = ((c0 >= w2 - 1) ? 1 : w2 - c0) + w2 * (h2 - 1 - r_end);
				repeat (rest) send_pixel(rand_pixel());
				w = w2;
				h = h2;
			end else begin
				repeat (w * h) send_pixel(rand_pixel());
			end
			frame_no++;
		end

		drain();
		@(negedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== cross_morphology_filter.f =====
hdl/cmf_pkg.sv
hdl/cmf_line_store.sv
hdl/cmf_raster_ctrl.sv
hdl/cmf_out_buf.sv
hdl/cross_morphology_filter.sv
tb/cmf_checker.sv
tb/tb_cross_morphology_filter.sv
